[rtl/core/bcdds_pkg.sv]
package bcdds_pkg;

   localparam int ValueWidth  = 32;
   localparam int DigitWidth  = 4;
   localparam int SelectWidth = 2;
   localparam int CountWidth  = 2;

   localparam int MaxDigits   = 3;
   localparam int SelectLines = 3;
   localparam int DigitCap    = (MaxDigits < SelectLines) ? MaxDigits : SelectLines;

   localparam logic [CountWidth-1:0] DigitCountReset = CountWidth'(3);
   localparam logic [CountWidth-1:0] DigitCapCode    = CountWidth'(DigitCap);

   // Reciprocal of ten: floor(v * Recip10 / 2^Recip10Shift) equals v / 10
   // for every 32-bit unsigned v.
   localparam logic [ValueWidth-1:0] Recip10      = 32'hCCCC_CCCD;
   localparam int                    Recip10Shift = 35;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic [CountWidth-1:0] count;
   } bcd_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/bcdds_req_if.sv]
interface bcdds_req_if;
   logic                              valid;
   logic                              ready;
   logic [bcdds_pkg::ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

[rtl/core/bcdds_rsp_if.sv]
interface bcdds_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bcdds_pkg::DigitWidth-1:0]  digit_code;
   logic [bcdds_pkg::SelectWidth-1:0] select_index;
   logic                               last_digit;

   modport source (output valid, output digit_code, output select_index, output last_digit,
                   input ready);
   modport sink (input valid, input digit_code, input select_index, input last_digit,
                 output ready);
endinterface

[rtl/core/binary_to_bcd_digit_display_sequencer.sv]
// Converts each 32-bit unsigned value on the request channel into its lowest
// digit_count decimal digits (higher digits are dropped) and sends them on the
// response channel one transaction per digit, most significant shown digit
// first, with select_index 0 on that digit and last_digit set on the final one.
// A digit_count of zero takes the request and sends nothing. For each job the
// back end takes it from the two-entry queue, runs it digit by digit through
// the shared divide-by-ten unit, then presents the digits, holding while the
// response stalls. The front end keeps taking requests while the queue has
// room. Write digit_count only while idle.
module binary_to_bcd_digit_display_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   bcdds_req_if.sink                         req_chan,
   bcdds_rsp_if.source                       rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [bcdds_pkg::CountWidth-1:0]  csr_write_data
);
   import bcdds_pkg::*;

   queue_status_type queue_status;
   bcd_job_type      push_job;
   bcd_job_type      pop_job;
   logic             push;
   logic             pop;

   bcdds_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .push             (push),
      .push_job         (push_job)
   );

   bcdds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (queue_status)
   );

   bcdds_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_job      (pop_job),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

[rtl/core/bcdds_front.sv]
module bcdds_front (
   input  logic                                clock,
   input  logic                                reset,
   bcdds_req_if.sink                           req_chan,
   input  logic                                csr_write_enable,
   input  logic [bcdds_pkg::CountWidth-1:0]    csr_write_data,
   input  bcdds_pkg::queue_status_type         queue_status,
   output logic                                push,
   output bcdds_pkg::bcd_job_type              push_job
);
   import bcdds_pkg::*;

   logic [CountWidth-1:0] digit_count_ff;
   logic [CountWidth-1:0] digit_count_in;
   logic [CountWidth-1:0] capped_count;

   always_comb begin
      digit_count_in = digit_count_ff;
      if (csr_write_enable) begin
         digit_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DigitCountReset;
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   assign capped_count = (digit_count_ff > DigitCapCode) ? DigitCapCode : digit_count_ff;

   assign req_chan.ready = !queue_status.full;

   // A transaction with a zero digit count is taken and dropped here.
   assign push           = req_chan.valid && !queue_status.full && (capped_count != '0);
   assign push_job.value = req_chan.value;
   assign push_job.count = capped_count;

endmodule

[rtl/core/bcdds_queue.sv]
module bcdds_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  bcdds_pkg::bcd_job_type       push_job,
   input  logic                         pop,
   output bcdds_pkg::bcd_job_type       pop_job,
   output bcdds_pkg::queue_status_type  status
);
   import bcdds_pkg::*;

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillWidth = $clog2(QueueDepth + 1);

   bcd_job_type           entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (fill_ff == FillWidth'(QueueDepth));
   assign status.empty = (fill_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/bcdds_back.sv]
module bcdds_back (
   input  logic                         clock,
   input  logic                         reset,
   input  bcdds_pkg::queue_status_type  queue_status,
   input  bcdds_pkg::bcd_job_type       pop_job,
   output logic                         pop,
   bcdds_rsp_if.source                  rsp_chan
);
   import bcdds_pkg::*;

   typedef enum logic [2:0] {
      BackIdle   = 3'b001,
      BackDivide = 3'b010,
      BackEmit   = 3'b100
   } back_state_type;

   localparam int ProductWidth = 2 * ValueWidth;

   back_state_type         state_ff, state_in;
   logic [ValueWidth-1:0]  work_ff, work_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [SelectWidth-1:0] index_ff, index_in;
   logic [DigitWidth-1:0]  digit_buffer_ff [SelectLines];

   logic [ProductWidth-1:0] product;
   logic [ValueWidth-1:0]   quotient;
   logic [ValueWidth-1:0]   times_ten;
   logic [ValueWidth-1:0]   remainder_wide;
   logic [DigitWidth-1:0]   remainder;
   logic                    rsp_done;

   // Divide by ten through the reciprocal, then recover the remainder.
   assign product        = ProductWidth'(work_ff) * ProductWidth'(Recip10);
   assign quotient       = ValueWidth'(product >> Recip10Shift);
   assign times_ten      = (quotient << 3) + (quotient << 1);
   assign remainder_wide = work_ff - times_ten;
   assign remainder      = remainder_wide[DigitWidth-1:0];

   assign rsp_chan.valid        = (state_ff == BackEmit);
   assign rsp_chan.digit_code   = digit_buffer_ff[index_ff];
   assign rsp_chan.select_index = index_ff;
   assign rsp_chan.last_digit   = (index_ff == SelectWidth'(count_ff - 1'b1));
   assign rsp_done              = rsp_chan.valid && rsp_chan.ready;

   assign pop = (state_ff == BackIdle) && !queue_status.empty;

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      count_in = count_ff;
      index_in = index_ff;
      case (state_ff)
         BackIdle: begin
            if (!queue_status.empty) begin
               work_in  = pop_job.value;
               count_in = pop_job.count;
               index_in = SelectWidth'(pop_job.count - 1'b1);
               state_in = BackDivide;
            end
         end
         BackDivide: begin
            // Digits are produced least significant first, filling the
            // buffer from entry count-1 toward entry zero.
            work_in = quotient;
            if (index_ff == '0) begin
               state_in = BackEmit;
            end else begin
               index_in = index_ff - 1'b1;
            end
         end
         BackEmit: begin
            if (rsp_done) begin
               if (rsp_chan.last_digit) begin
                  index_in = '0;
                  state_in = BackIdle;
               end else begin
                  index_in = index_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BackIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BackIdle;
         work_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         work_ff  <= work_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BackDivide) begin
         digit_buffer_ff[index_ff] <= remainder;
      end
   end

endmodule

[tb/tb.sv]
module tb;
   import bcdds_pkg::*;

   localparam int DrainCycles = 30;

   typedef struct packed {
      logic [DigitWidth-1:0]  digit;
      logic [SelectWidth-1:0] select;
      logic                   last;
   } digit_result_type;

   class digit_scoreboard;
      digit_result_type expected_digits[$];
      int               errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] %s", $time, what);
         end
      endfunction

      // Splits one value into its lowest shown digits and queues one
      // expected transaction per digit, most significant shown digit first.
      function void note_value(logic [ValueWidth-1:0] value, logic [CountWidth-1:0] count);
         logic [ValueWidth-1:0] work;
         logic [DigitWidth-1:0] digits[MaxDigits];
         int                    shown;
         digit_result_type      item;

         shown = (int'(count) > DigitCap) ? DigitCap : int'(count);
         work  = value;
         for (int i = shown - 1; i >= 0; i--) begin
            digits[i] = DigitWidth'(work % 10);
            work      = work / 10;
         end
         for (int i = 0; i < shown; i++) begin
            item.digit  = digits[i];
            item.select = SelectWidth'(i);
            item.last   = (i == shown - 1);
            expected_digits.push_back(item);
         end
      endfunction

      function void check_digit(logic [DigitWidth-1:0] digit, logic [SelectWidth-1:0] select,
                                logic last);
         digit_result_type want;

         if (expected_digits.size() == 0) begin
            flag($sformatf("unexpected digit %0d select %0d last %0d", digit, select, last));
            return;
         end
         want = expected_digits.pop_front();
         if (digit !== want.digit) begin
            flag($sformatf("digit_code expected %0d got %0d", want.digit, digit));
         end
         if (select !== want.select) begin
            flag($sformatf("select_index expected %0d got %0d", want.select, select));
         end
         if (last !== want.last) begin
            flag($sformatf("last_digit expected %0d got %0d", want.last, last));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CountWidth-1:0] csr_write_data;
   logic [CountWidth-1:0] shown_digits;
   bit                    steady;
   digit_scoreboard       board;

   bcdds_req_if req_if ();
   bcdds_rsp_if rsp_if ();

   binary_to_bcd_digit_display_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Mostly back to back, sometimes a short gap, now and then a long pause; always back to back when steady is set.
   function automatic int pick_gap();
      int roll;

      roll = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ValueWidth-1:0] pick_value();
      logic [ValueWidth-1:0] tens;

      tens = 1;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5:       return $urandom_range(0, 999);
         6:          return $urandom_range(0, 9);
         7: begin
            repeat ($urandom_range(0, 9)) tens = tens * 10;
            return tens - $urandom_range(0, 1);
         end
         8:          return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default:    return $urandom() & $urandom();
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_digit(rsp_if.digit_code, rsp_if.select_index, rsp_if.last_digit);
      end
   end

   initial begin
      int stall;

      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic send_value(input logic [ValueWidth-1:0] value);
      int gap;

      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_value(value, shown_digits);
   endtask

   // Wait until every digit has come back, then give the block time to finish
   // any zero-count transactions that produce nothing.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_digit_count(input logic [CountWidth-1:0] count);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shown_digits = count;
   endtask

   task automatic send_random(input logic [CountWidth-1:0] count, input int items);
      write_digit_count(count);
      repeat (items) send_value(pick_value());
   endtask

   initial begin
      board            = new();
      steady           = 1'b0;
      shown_digits     = DigitCountReset;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.value     <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed values: digit boundaries, top-bit, all-ones and alternating patterns.
      write_digit_count(2'd3);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'd999);
      send_value(32'd1000);
      send_value(32'd12345);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      write_digit_count(2'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'hFFFF_FFFF);
      write_digit_count(2'd2);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'hFFFF_FFFF);
      // A zero digit count swallows the value and emits nothing.
      write_digit_count(2'd0);
      send_value(32'd12345);
      send_value(32'd0);

      send_random(2'd3, 35);
      send_random(2'd1, 15);
      send_random(2'd2, 20);
      send_random(2'd0, 8);
      steady = 1'b1;
      send_random(2'd3, 31);
      steady = 1'b0;

      settle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
